>>> src/itrb_pkg.sv
package itrb_pkg;

   // Frame and palette geometry.
   localparam int FRAME_WIDTH   = 384;
   localparam int FRAME_HEIGHT  = 224;
   localparam int BANK_COUNT    = 32;
   localparam int PENS_PER_BANK = 16;

   localparam int LANES     = 8;
   localparam int PEN_W     = 4;
   localparam int COLOR_W   = 16;
   localparam int COORD_W   = 11;
   localparam int ADDR_W    = 17;
   localparam int BANK_W    = 5;
   localparam int GROUP_W   = 3;
   localparam int ROW_W     = 3;
   localparam int META_W    = 8;
   localparam int PAL_DEPTH = BANK_COUNT * PENS_PER_BANK;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int YW        = $clog2(FRAME_HEIGHT);

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 48;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      ACT_PAL_WRITE = 1'b0,
      ACT_BLIT      = 1'b1
   } action_type;

   typedef logic [PAL_AW-1:0] pal_addr_type;
   typedef pal_addr_type bank_table_type [2**BANK_W];

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic                 pad;
      logic [COLOR_W-1:0]   write_color;
      logic [PEN_W-1:0]     pen_index;
      logic                 meta_enable;
      logic [GROUP_W-1:0]   pri_group;
      logic [BANK_W-1:0]    pal_bank;
      logic                 flip_x;
      logic [ROW_W-1:0]     row;
      logic [COORD_W-1:0]   dst_y;
      logic [COORD_W-1:0]   dst_x;
      logic [31:0]          row_pixels;
   } req_data_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [6:0]           pad;
      logic [META_W-1:0]    meta_byte;
      logic [COLOR_W-1:0]   pixel_color;
      logic [ADDR_W-1:0]    pixel_address;
   } rsp_data_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      logic                          is_write;
      pal_addr_type                  pal_addr;
      logic [COLOR_W-1:0]            color;
      logic [LANES-1:0]              mask;
      logic [LANES-1:0][PEN_W-1:0]   pens;
      logic [COORD_W-1:0]            x0;
      logic [ADDR_W-1:0]             row_base;
      logic                          meta_en;
      logic [GROUP_W-1:0]            group;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Palette base address of each bank code, with the bank taken modulo
   // the number of banks.
   function automatic bank_table_type make_bank_base();
      bank_table_type t;
      for (int i = 0; i < 2**BANK_W; i++) begin
         t[i] = PAL_AW'((i % BANK_COUNT) * PENS_PER_BANK);
      end
      return t;
   endfunction

   localparam bank_table_type BANK_BASE = make_bank_base();

endpackage

>>> src/itrb_front.sv
module itrb_front (
   input  logic                             req_accept,
   input  logic [itrb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   output logic                             push,
   output itrb_pkg::cmd_type                cmd
);

   itrb_pkg::req_data_type                                  req;
   logic [itrb_pkg::COORD_W:0]                              py;
   logic [itrb_pkg::COORD_W:0]                              px [itrb_pkg::LANES];
   logic                                                    y_ok;
   logic [itrb_pkg::LANES-1:0]                              mask;
   logic [itrb_pkg::LANES-1:0][itrb_pkg::PEN_W-1:0]         pens;
   logic [2:0]                                              src;
   logic [7:0]                                              byte_val;
   logic                                                    is_write;

   assign req      = itrb_pkg::req_data_type'(req_tdata);
   assign is_write = (itrb_pkg::action_type'(req_tuser) == itrb_pkg::ACT_PAL_WRITE);

   // Screen row: sign-extended tile y plus the row within the tile.
   assign py   = {req.dst_y[itrb_pkg::COORD_W-1], req.dst_y} +
                 (itrb_pkg::COORD_W+1)'(req.row);
   assign y_ok = !py[itrb_pkg::COORD_W] &&
                 (py < (itrb_pkg::COORD_W+1)'(itrb_pkg::FRAME_HEIGHT));

   // Pens in destination order; each lane checks its own column.
   always_comb begin
      for (int c = 0; c < itrb_pkg::LANES; c++) begin
         src      = req.flip_x ? 3'(7 - c) : 3'(c);
         byte_val = req.row_pixels[src[2:1]*8 +: 8];
         pens[c]  = src[0] ? byte_val[3:0] : byte_val[7:4];
         px[c]    = {req.dst_x[itrb_pkg::COORD_W-1], req.dst_x} + (itrb_pkg::COORD_W+1)'(c);
         mask[c]  = y_ok && !px[c][itrb_pkg::COORD_W] &&
                    (px[c] < (itrb_pkg::COORD_W+1)'(itrb_pkg::FRAME_WIDTH)) &&
                    (pens[c] != '0);
      end
   end

   // A row carries only the bank base; the back end adds each pixel's pen.
   always_comb begin
      cmd          = '0;
      cmd.is_write = is_write;
      cmd.pal_addr = itrb_pkg::BANK_BASE[req.pal_bank] |
                     itrb_pkg::PAL_AW'(is_write ? req.pen_index : '0);
      cmd.color    = req.write_color;
      cmd.mask     = mask;
      cmd.pens     = pens;
      cmd.x0       = req.dst_x;
      cmd.row_base = itrb_pkg::ADDR_W'(py[itrb_pkg::YW-1:0] *
                                       itrb_pkg::ADDR_W'(itrb_pkg::FRAME_WIDTH));
      cmd.meta_en  = req.meta_enable;
      cmd.group    = req.pri_group;
   end

   // Rows that write nothing never reach the back end.
   assign push = req_accept && (is_write || (mask != '0));

endmodule

>>> src/itrb_queue.sv
module itrb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  itrb_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output itrb_pkg::cmd_type          pop_cmd,
   output itrb_pkg::queue_status_type status
);

   itrb_pkg::cmd_type               entries_ff [itrb_pkg::QUEUE_DEPTH];
   logic [itrb_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [itrb_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [itrb_pkg::QUEUE_AW:0]     count_ff, count_in;

   assign status.full  = (count_ff == (itrb_pkg::QUEUE_AW+1)'(itrb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_cmd      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (itrb_pkg::QUEUE_AW+1)'(push) - (itrb_pkg::QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/itrb_back.sv
module itrb_back (
   input  logic                             clock,
   input  logic                             reset,
   input  itrb_pkg::queue_status_type       q_status,
   input  itrb_pkg::cmd_type                q_cmd,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [itrb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   logic [itrb_pkg::COLOR_W-1:0]   palette_mem [itrb_pkg::PAL_DEPTH];

   itrb_pkg::cmd_type              cur_ff, cur_in;
   logic                           busy_ff, busy_in;
   logic                           out_valid_ff, out_valid_in;
   logic [itrb_pkg::COLOR_W-1:0]   pal_rd_ff;
   logic [itrb_pkg::ADDR_W-1:0]    out_addr_ff;
   logic [itrb_pkg::META_W-1:0]    out_meta_ff;
   logic                           out_meta_wr_ff;
   logic                           out_last_ff;

   logic [2:0]                     lane;
   logic [itrb_pkg::PEN_W-1:0]     pen;
   logic [itrb_pkg::COORD_W-1:0]   px;
   logic [itrb_pkg::ADDR_W-1:0]    pix_addr;
   logic                           single;
   logic                           advance;
   logic                           do_write;
   logic                           emit;
   logic                           done;
   itrb_pkg::rsp_data_type         rsp_d;

   // Lowest remaining column goes next.
   always_comb begin
      lane = '0;
      for (int i = itrb_pkg::LANES - 1; i >= 0; i--) begin
         if (cur_ff.mask[i]) begin
            lane = 3'(i);
         end
      end
   end

   assign pen      = cur_ff.pens[lane];
   assign px       = cur_ff.x0 + itrb_pkg::COORD_W'(lane);
   assign pix_addr = cur_ff.row_base + itrb_pkg::ADDR_W'(px);
   assign single   = ((cur_ff.mask & (cur_ff.mask - 1'b1)) == '0);

   assign advance  = !out_valid_ff || rsp_tready;
   assign do_write = busy_ff && cur_ff.is_write;
   assign emit     = busy_ff && !cur_ff.is_write && advance;
   assign done     = do_write || (emit && single);
   assign q_pop    = !q_status.empty && (!busy_ff || done);

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         cur_in  = q_cmd;
         busy_in = 1'b1;
      end else begin
         if (emit) begin
            cur_in.mask = cur_ff.mask & (cur_ff.mask - 1'b1);
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
      out_valid_in = advance ? emit : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_addr_ff    <= pix_addr;
         out_meta_wr_ff <= cur_ff.meta_en;
         out_meta_ff    <= cur_ff.meta_en ? {1'b1, cur_ff.group, pen} : '0;
         out_last_ff    <= single;
      end
   end

   // Palette memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         palette_mem[cur_ff.pal_addr] <= cur_ff.color;
      end
      if (emit) begin
         pal_rd_ff <= palette_mem[cur_ff.pal_addr | itrb_pkg::PAL_AW'(pen)];
      end
   end

   always_comb begin
      rsp_d               = '0;
      rsp_d.pixel_address = out_addr_ff;
      rsp_d.pixel_color   = pal_rd_ff;
      rsp_d.meta_byte     = out_meta_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_d;
   assign rsp_tuser  = out_meta_wr_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/indexed_tile_row_blitter.sv
// Indexed tile row blitter. Each request either loads one palette entry
// (tuser = 0) or draws one eight-pixel row of a 4-bit-per-pixel tile
// (tuser = 1). A drawn row produces one response per visible pixel, that
// is, per nonzero pen whose column and row fall inside the frame, in
// order from the leftmost destination column, with tlast on the final one;
// a row with no visible pixel and a palette load produce no response.
// The back end emits one pixel per cycle unless the response channel
// stalls, so a row holds the channel until its last pixel is taken;
// that rate is set by the single palette read port and the single
// response channel. With the back end idle, an accepted request passes
// the queue and the current-row register into the output registers,
// which present its first pixel. A four-entry queue between the front end
// and the back end lets requests keep arriving while earlier rows drain.
// Palette entries must be loaded before a row reads them.
module indexed_tile_row_blitter (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: row_pixels, dst_x, dst_y, row, flip_x,
   // pal_bank, pri_group, meta_enable, pen_index, write_color,
   // then one zero bit.
   input  logic [itrb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields: action (0 loads a palette entry, 1 draws a row).
   input  logic                             req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0 up: pixel_address, pixel_color, meta_byte,
   // then seven zero bits.
   output logic [itrb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Fields: meta_write.
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   logic                       req_accept;
   logic                       push;
   logic                       pop;
   itrb_pkg::cmd_type          push_cmd;
   itrb_pkg::cmd_type          pop_cmd;
   itrb_pkg::queue_status_type q_status;

   // A request is taken whenever the queue has room, regardless of
   // whether the back end is still emitting pixels.
   assign req_tready = !q_status.full;
   assign req_accept = req_tvalid && req_tready;

   // The front end decodes the request, clips each column against the
   // frame and computes the row's base address.
   itrb_front u_front (
      .req_accept (req_accept),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .cmd        (push_cmd)
   );

   itrb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   // The back end owns the palette memory and walks the visible columns.
   itrb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_cmd      (pop_cmd),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/itrb_checker.sv
module itrb_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [itrb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [itrb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             rsp_tlast
);

   itrb_pkg::rsp_data_type rsp_d;

   assign rsp_d = itrb_pkg::rsp_data_type'(rsp_tdata);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // Reset empties the queue and the output stage.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

   // A meta write always carries the valid bit and a visible pen.
   a_meta_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_d.meta_byte[7] && (rsp_d.meta_byte[3:0] != '0))
      else $error("meta byte malformed");

   // Without a meta write the meta byte and the padding are zero.
   a_meta_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_d.meta_byte == '0) && (rsp_d.pad == '0))
      else $error("meta byte or padding not zero");

endmodule

bind indexed_tile_row_blitter itrb_checker u_itrb_checker (.*);

>>> test/indexed_tile_row_blitter_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the blitter, keeps its own palette copy, works out the
// pixel writes that each accepted request must cause, and compares them in order.
module indexed_tile_row_blitter_checker
   import itrb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tlast,
   output int                     failures,
   output int                     pending
);

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [COLOR_W-1:0] color;
      logic               meta_write;
      logic [META_W-1:0]  meta_byte;
      logic               last;
   } pixel_write_type;

   logic [COLOR_W-1:0] palette_copy [PAL_DEPTH];
   pixel_write_type    pixel_writes_due [$];
   int                 failure_count = 0;
   int                 reported = 0;

   initial begin
      failures = 0;
      pending = 0;
   end

   // Produces the pixel writes of one tile row, leftmost destination column first.
   task automatic draw_row(input req_data_type d);
      pixel_write_type row_writes [$];
      pixel_write_type w;
      int              y;
      int              x;
      int              src;
      logic [7:0]      pair;
      logic [3:0]      pen;
      y = int'($signed(d.dst_y)) + int'(d.row);
      if (y >= 0 && y < FRAME_HEIGHT) begin
         for (int col = 0; col < LANES; col++) begin
            x = int'($signed(d.dst_x)) + col;
            src = d.flip_x ? (LANES - 1 - col) : col;
            pair = d.row_pixels[(src / 2) * 8 +: 8];
            pen = (src % 2 == 1) ? pair[3:0] : pair[7:4];
            if (x >= 0 && x < FRAME_WIDTH && pen != 4'd0) begin
               w.address = ADDR_W'(y * FRAME_WIDTH + x);
               w.color = palette_copy[(int'(d.pal_bank) % BANK_COUNT) * PENS_PER_BANK
                                      + int'(pen)];
               w.meta_write = d.meta_enable;
               w.meta_byte = d.meta_enable ? {1'b1, d.pri_group, pen} : 8'h00;
               w.last = 1'b0;
               row_writes.push_back(w);
            end
         end
      end
      if (row_writes.size() > 0) begin
         row_writes[row_writes.size() - 1].last = 1'b1;
      end
      foreach (row_writes[i]) begin
         pixel_writes_due.push_back(row_writes[i]);
      end
   endtask

   always @(posedge clock) begin : monitor
      req_data_type    d;
      rsp_data_type    r;
      pixel_write_type got;
      pixel_write_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            d = req_data_type'(req_tdata);
            if (action_type'(req_tuser) == ACT_PAL_WRITE) begin
               palette_copy[(int'(d.pal_bank) % BANK_COUNT) * PENS_PER_BANK
                            + int'(d.pen_index)] = d.write_color;
            end else begin
               draw_row(d);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            r = rsp_data_type'(rsp_tdata);
            got.address = r.pixel_address;
            got.color = r.pixel_color;
            got.meta_write = rsp_tuser;
            got.meta_byte = r.meta_byte;
            got.last = rsp_tlast;
            if (pixel_writes_due.size() == 0) begin
               failure_count++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected pixel write: addr %0d color %h meta %b/%h last %b",
                           got.address, got.color, got.meta_write, got.meta_byte, got.last);
               end
            end else begin
               want = pixel_writes_due.pop_front();
               if (got !== want) begin
                  failure_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("pixel write mismatch: expected addr %0d color %h meta %b/%h last %b",
                              want.address, want.color, want.meta_write, want.meta_byte,
                              want.last);
                     $display("                      got      addr %0d color %h meta %b/%h last %b",
                              got.address, got.color, got.meta_write, got.meta_byte, got.last);
                  end
               end
            end
         end
      end
      failures <= failure_count;
      pending <= pixel_writes_due.size();
   end

endmodule

>>> test/indexed_tile_row_blitter_tb.sv
`timescale 1ns / 1ps

// Top of the blitter testbench. It only makes stimulus and gives the verdict; all
// prediction and comparison lives in the checker instantiated beside the block.
module indexed_tile_row_blitter_tb;
   import itrb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   int                     failures;
   int                     pending;

   // Which palette entries have been loaded so far. A row may only use a nonzero
   // pen whose entry in its bank is loaded, since reading an unloaded entry is
   // outside what the block promises.
   bit pen_loaded [BANK_COUNT][PENS_PER_BANK];

   int sent = 0;
   int taken = 0;
   bit draining = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   indexed_tile_row_blitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   indexed_tile_row_blitter_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .pending    (pending)
   );

   // Offers one request and returns at the edge where it is accepted. Before it the
   // sender idles for a random number of cycles, except in every third stretch of
   // twelve requests, where requests follow back to back. The valid is only
   // lowered when there really is a gap, so it never gets two updates in one step.
   task automatic send_request(input action_type act, input req_data_type d);
      int gap;
      gap = ((sent / 12) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= d;
      req_tuser <= act;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // Loads one palette entry. The row fields ride along with random content, since
   // the block must ignore them for a palette load.
   task automatic load_pen(input int bank, input int pen, input logic [COLOR_W-1:0] color);
      req_data_type d;
      d = req_data_type'(REQ_TDATA_W'({$urandom, $urandom, $urandom}));
      d.pad = 1'b0;
      d.pal_bank = BANK_W'(bank);
      d.pen_index = PEN_W'(pen);
      d.write_color = color;
      pen_loaded[bank % BANK_COUNT][pen] = 1'b1;
      send_request(ACT_PAL_WRITE, d);
   endtask

   // Draws one tile row. The palette load fields carry random content.
   task automatic draw_row(input logic [31:0] pixels, input int x, input int y, input int row,
                           input logic flip, input int bank, input int group,
                           input logic meta);
      req_data_type d;
      d.pad = 1'b0;
      d.write_color = COLOR_W'($urandom);
      d.pen_index = PEN_W'($urandom);
      d.meta_enable = meta;
      d.pri_group = GROUP_W'(group);
      d.pal_bank = BANK_W'(bank);
      d.flip_x = flip;
      d.row = ROW_W'(row);
      d.dst_y = COORD_W'(y);
      d.dst_x = COORD_W'(x);
      d.row_pixels = pixels;
      send_request(ACT_BLIT, d);
   endtask

   // A quarter of the pens are transparent; the rest come from the loaded entries of
   // the bank, falling back to transparent while the bank has none.
   function automatic logic [PEN_W-1:0] pick_pen(input int bank);
      int choices [$];
      if ($urandom_range(0, 3) == 0) begin
         return '0;
      end
      for (int p = 1; p < PENS_PER_BANK; p++) begin
         if (pen_loaded[bank % BANK_COUNT][p]) begin
            choices.push_back(p);
         end
      end
      if (choices.size() == 0) begin
         return '0;
      end
      return PEN_W'(choices[$urandom_range(0, choices.size() - 1)]);
   endfunction

   // Within each tile byte the high nibble is the left pixel of the pair.
   function automatic logic [31:0] random_pixels(input int bank);
      logic [31:0] pixels;
      for (int src = 0; src < LANES; src++) begin
         pixels[(src / 2) * 8 + ((src % 2 == 1) ? 0 : 4) +: 4] = pick_pen(bank);
      end
      return pixels;
   endfunction

   // The receiver takes each pixel write after a random wait, except in every third
   // stretch of sixteen writes and while draining at the end. Once, after twenty
   // writes, it holds off for a long stretch while the sender keeps offering
   // requests, so that the queue inside the block fills and the request side stalls.
   initial begin : receiver
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 20) begin
            gap = 300;
         end else if (draining || (taken / 16) % 3 == 2) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 15);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      int bank;
      int x;
      int y;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Fill bank 31 completely, with the all-ones and all-zeros colors at the
      // ends, and give bank 0 a couple of entries, one of them its pen 0.
      load_pen(31, 1, 16'h0000);
      for (int p = 2; p < 15; p++) begin
         load_pen(31, p, COLOR_W'($urandom));
      end
      load_pen(31, 15, 16'hFFFF);
      load_pen(0, 0, 16'h0000);
      load_pen(0, 15, 16'h5A5A);

      // A full row of the top pen in the top-left corner, meta on with the top group.
      draw_row(32'hFFFF_FFFF, 0, 0, 0, 1'b0, 31, 7, 1'b1);
      // Pens one to eight, mirrored, in the bottom-right corner, meta off.
      draw_row(32'h1234_5678, FRAME_WIDTH - 8, FRAME_HEIGHT - 8, 7, 1'b1, 31, 0, 1'b0);
      // Transparent pens mixed in, clipped on the left.
      draw_row(32'h0F0F_00F0, -4, 100, 3, 1'b0, 0, 5, 1'b1);
      // Clipped on the right, mirrored.
      draw_row(32'h89AB_CDEF, FRAME_WIDTH - 4, 50, 2, 1'b1, 31, 3, 1'b1);
      // Rows that lie wholly off the frame on each side give no pixel writes.
      draw_row(32'hFFFF_FFFF, -1024, 10, 0, 1'b0, 31, 1, 1'b1);
      draw_row(32'hFFFF_FFFF, 1023, 10, 0, 1'b0, 31, 1, 1'b1);
      draw_row(32'hFFFF_FFFF, 10, -1024, 0, 1'b0, 31, 1, 1'b1);
      draw_row(32'hFFFF_FFFF, 10, 1023, 7, 1'b1, 31, 1, 1'b1);
      // The row offset brings a tile above the frame onto its top line, and pushes
      // another just past its bottom line.
      draw_row(32'h1F2E_3D4C, 20, -3, 3, 1'b0, 31, 2, 1'b0);
      draw_row(32'h1F2E_3D4C, 20, FRAME_HEIGHT - 4, 4, 1'b0, 31, 2, 1'b0);
      // A fully transparent row gives no pixel write either.
      draw_row(32'h0000_0000, 30, 30, 1, 1'b0, 31, 6, 1'b1);

      // Random part: about a third palette loads, the rest tile rows. Most rows sit
      // near the frame so that they are partly or fully visible, and half of them
      // use the fully loaded bank so that they carry many pixel writes.
      for (int n = 0; n < 83; n++) begin
         if ($urandom_range(0, 9) < 3) begin
            load_pen($urandom_range(0, 31), $urandom_range(0, 15), COLOR_W'($urandom));
         end else begin
            bank = ($urandom_range(0, 1) == 0) ? 31 : $urandom_range(0, 31);
            if ($urandom_range(0, 4) == 0) begin
               x = $urandom_range(0, 2047) - 1024;
               y = $urandom_range(0, 2047) - 1024;
            end else begin
               x = $urandom_range(0, FRAME_WIDTH + 8) - 8;
               y = $urandom_range(0, FRAME_HEIGHT + 8) - 8;
            end
            draw_row(random_pixels(bank), x, y, $urandom_range(0, 7), 1'($urandom), bank,
                     $urandom_range(0, 7), 1'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // Wait for every expected pixel write, then give the block time to show any
      // write it should not make, with the receiver always ready.
      while (pending != 0) @(posedge clock);
      draining = 1'b1;
      repeat (40) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every request waiting out the longest
   // sender gap and every pixel write the longest receiver stall.
   initial begin : watchdog
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
